>>> hw/rtl/bsort_pkg.sv
// ----------------------------------------------------------------------------
// bsort_pkg
// Shared constants, state type and command struct of the bubble sorter.
// ----------------------------------------------------------------------------
package bsort_pkg;

    localparam int SET_MAX = 64;
    localparam int IDX_W   = $clog2(SET_MAX);
    localparam int CNT_W   = $clog2(SET_MAX + 1);
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // register index of sort_mode
    localparam logic REG_SORT_MODE = 1'b0;

    localparam logic MODE_DESC_VALUE = 1'b0;
    localparam logic MODE_ASC_MAG    = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } bsort_state_t;

    typedef struct packed {
        logic             load_en;
        logic             sort_en;
        logic             sort_phase;
        logic             shift_en;
        logic [CNT_W-1:0] count;
    } bsort_cmd_t;

endpackage

>>> hw/rtl/bubble_sorter_with_comparator_mode_top.sv
// ----------------------------------------------------------------------------
// bubble_sorter_with_comparator_mode_top
// Collects a set of signed 32-bit values, sorts it and streams it back out.
// ----------------------------------------------------------------------------
// Send up to 64 values, one per item, with tlast on the final one. Values
// past the 64th are dropped (the closing item's value too). The sort then
// runs one odd-even transposition round per cycle over the row of element
// cells, as many rounds as the set has elements, and the sorted set leaves
// one element per cycle while the result side keeps tready high. The input
// side is stalled from the closing item until the last sorted element has
// been loaded into the output register. sort_mode (APB byte address 0,
// bit 0) selects the order: 0 descending by signed value, 1 ascending by
// magnitude (the minimum integer counts as 2^31); equal keys keep their
// arrival order. The mode is sampled during the sort; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
module bubble_sorter_with_comparator_mode_top
    import bsort_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value_in
    input  logic              s_tlast,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] value_out
    output logic              m_tlast,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       sort_mode_reg;
    logic       sort_mode_next;
    logic       reg_hit;
    bsort_cmd_t cmd;

    // register index is the word address
    assign reg_hit = (paddr[ADDR_W-1] == REG_SORT_MODE);
    assign pready  = 1'b1;

    always_comb begin
        sort_mode_next = sort_mode_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            sort_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_mode_reg <= MODE_DESC_VALUE;
        end else begin
            sort_mode_reg <= sort_mode_next;
        end
    end

    // read back the mode; anything else reads as zero
    assign prdata = reg_hit ? {31'b0, sort_mode_reg} : 32'b0;

    bsort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    bsort_datapath u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .sort_mode (sort_mode_reg),
        .value_in  (s_tdata),
        .value_out (m_tdata)
    );

endmodule

>>> hw/rtl/bsort_datapath.sv
// ----------------------------------------------------------------------------
// bsort_datapath
// Row of element cells with odd-even compare-exchange and an output shift.
// ----------------------------------------------------------------------------
module bsort_datapath
    import bsort_pkg::*;
(
    input  logic              aclk,
    input  bsort_cmd_t        cmd,
    input  logic              sort_mode,
    input  logic [DATA_W-1:0] value_in,
    output logic [DATA_W-1:0] value_out
);

    logic [DATA_W-1:0] cell_reg  [SET_MAX];
    logic [DATA_W-1:0] cell_next [SET_MAX];
    logic [DATA_W-1:0] out_reg;
    logic [DATA_W-1:0] out_next;
    logic [SET_MAX-2:0] swap;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        magnitude = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // pair j is out of order when the lower cell must move up
    always_comb begin
        for (int j = 0; j < SET_MAX - 1; j++) begin
            if (sort_mode == MODE_ASC_MAG) begin
                swap[j] = magnitude(cell_reg[j]) > magnitude(cell_reg[j+1]);
            end else begin
                swap[j] = $signed(cell_reg[j]) < $signed(cell_reg[j+1]);
            end
        end
    end

    always_comb begin
        cell_next = cell_reg;
        out_next  = out_reg;
        if (cmd.load_en) begin
            cell_next[cmd.count[IDX_W-1:0]] = value_in;
        end else if (cmd.sort_en) begin
            for (int j = 0; j < SET_MAX - 1; j++) begin
                if ((j % 2 == int'(cmd.sort_phase)) && (CNT_W'(j + 1) < cmd.count)
                    && swap[j]) begin
                    cell_next[j]   = cell_reg[j+1];
                    cell_next[j+1] = cell_reg[j];
                end
            end
        end else if (cmd.shift_en) begin
            out_next = cell_reg[0];
            for (int i = 0; i < SET_MAX - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
        out_reg  <= out_next;
    end

    assign value_out = out_reg;

endmodule

>>> hw/rtl/bsort_ctrl.sv
// ----------------------------------------------------------------------------
// bsort_ctrl
// Load / sort / emit sequencer with element count, pass count and output flags.
// ----------------------------------------------------------------------------
module bsort_ctrl
    import bsort_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_tlast,
    output bsort_cmd_t cmd
);

    bsort_state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pass_reg,  pass_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_last_reg,  m_last_next;
    logic             in_acc;
    logic             out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            pass_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pass_next    = pass_reg;
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        cmd          = '0;
        cmd.count    = count_reg;
        cmd.sort_phase = pass_reg[0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    // drop values past a full set
                    if (count_reg < CNT_W'(SET_MAX)) begin
                        cmd.load_en = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        pass_next  = '0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                cmd.sort_en = 1'b1;
                pass_next   = pass_reg + 1'b1;
                if (pass_reg == count_reg - 1'b1) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    cmd.shift_en = 1'b1;
                    m_valid_next = 1'b1;
                    m_last_next  = (count_reg == CNT_W'(1));
                    count_next   = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SET_MAX))
        else $error("element count above set size");

    a_last_starts_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == ST_SORT))
        else $error("closing item did not start the sort");

    a_sort_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SORT || state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("sort or emit with an empty set");

    a_last_out_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && count_reg == CNT_W'(1)) |=> (m_tlast && state_reg == ST_LOAD))
        else $error("final element not marked last");

endmodule
